// ===== design/lsc_pkg.sv =====
// Shared constants and types for the line sensor centroid block.
package lsc_pkg;

   localparam int NUM_SENSORS = 11;
   localparam int SAMPLE_BITS = 9;
   localparam int POS_W       = $clog2(NUM_SENSORS + 1);
   localparam int HIT_W       = $clog2(NUM_SENSORS + 1);
   localparam int SUM_W       = 16;
   localparam int OUT_W       = 14;
   localparam int STEP_W      = $clog2(SUM_W);

   localparam logic [SUM_W-1:0]       WEIGHT_STEP     = SUM_W'(1000);
   localparam logic [OUT_W-1:0]       CENTRE_POS      = OUT_W'(5000);
   localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(200);

   // One scan's totals, handed from the accumulator to the control.
   typedef struct packed {
      logic [SUM_W-1:0]       sum;
      logic [HIT_W-1:0]       hits;
      logic [NUM_SENSORS-1:0] bits;
   } scan_type;

   // Divider status toward the control.
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SUM_W-1:0] quotient;
   } div_stat_type;

endpackage

// ===== design/lsc_acc.sv =====
// Per-scan accumulator: sensor index, weighted sum, hit count and hit bits.
module lsc_acc (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             take,
   input  logic [lsc_pkg::SAMPLE_BITS-1:0]  sample,
   input  logic                             last,
   input  logic [lsc_pkg::SAMPLE_BITS-1:0]  threshold,
   output lsc_pkg::scan_type                scan_next
);
   import lsc_pkg::*;

   logic [POS_W-1:0] position_ff, position_in;
   logic [SUM_W-1:0] weight_ff, weight_in;
   scan_type         scan_ff, scan_in;
   logic             in_range;
   logic             hit;

   assign in_range = position_ff < POS_W'(NUM_SENSORS);
   assign hit      = in_range && (sample > threshold);

   always_comb begin
      scan_next = scan_ff;
      if (hit) begin
         scan_next.sum  = scan_ff.sum + weight_ff;
         scan_next.hits = scan_ff.hits + HIT_W'(1);
         for (int i = 0; i < NUM_SENSORS; i++) begin
            if (position_ff == POS_W'(i)) begin
               scan_next.bits[i] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      position_in = position_ff;
      weight_in   = weight_ff;
      scan_in     = scan_ff;
      if (take) begin
         if (last) begin
            // scan ends: clear for the next one
            position_in = '0;
            weight_in   = '0;
            scan_in     = '0;
         end else begin
            scan_in = scan_next;
            if (in_range) begin
               position_in = position_ff + POS_W'(1);
               weight_in   = weight_ff + WEIGHT_STEP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff <= '0;
         weight_ff   <= '0;
         scan_ff     <= '0;
      end else begin
         position_ff <= position_in;
         weight_ff   <= weight_in;
         scan_ff     <= scan_in;
      end
   end

endmodule

// ===== design/lsc_div.sv =====
// Restoring divider, one quotient bit per cycle through one shared subtractor.
module lsc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lsc_pkg::SUM_W-1:0]   dividend,
   input  logic [lsc_pkg::HIT_W-1:0]   divisor,
   output lsc_pkg::div_stat_type       stat
);
   import lsc_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [HIT_W-1:0]  dvsr_ff, dvsr_in;
   logic [HIT_W-1:0]  rem_ff, rem_in;
   logic [HIT_W:0]    trial;
   logic [HIT_W+1:0]  diff;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         // keep the difference unless the subtract borrowed
         if (diff[HIT_W+1]) begin
            rem_in = trial[HIT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end else begin
            rem_in = diff[HIT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
      rem_ff  <= rem_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff;

endmodule

// ===== design/line_sensor_centroid.sv =====
// Line sensor centroid: threshold, accumulate and divide one scan per result.
// A sample with tlast starts the divide; its result is loaded into the output
// register once the 16 divider steps are done.
// Throughput: one sample per cycle inside a scan; the 16-step serial divider
// holds req_tready low after each tlast sample until its result is loaded, longer
// while the previous result still waits on rsp_tready.
// Reset (synchronous, active high): threshold returns to 200, scan totals clear.
module line_sensor_centroid (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // [8:0] sample, [15:9] zero
   input  logic        req_tlast,    // last sensor of the scan
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // [13:0] position, [27:14] centred_error,
                                     // [38:28] sensor_bits, [39] zero
   output logic        rsp_tuser,    // line_seen
   // threshold register
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);
   import lsc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [SAMPLE_BITS-1:0] threshold_ff, threshold_in;
   logic                   req_take;
   logic                   div_start;
   scan_type               scan_next;
   div_stat_type           div_stat;

   // scan attributes that ride alongside the division
   logic [NUM_SENSORS-1:0] bits_ff, bits_in;
   logic                   seen_ff, seen_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [OUT_W-1:0]       rsp_err_ff, rsp_err_in;
   logic [NUM_SENSORS-1:0] rsp_bits_ff, rsp_bits_in;
   logic                   rsp_seen_ff, rsp_seen_in;
   logic                   out_free;
   logic                   load;

   // Samples flow in only between scans' divisions.
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign div_start  = req_take && req_tlast;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   lsc_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .take      (req_take),
      .sample    (req_tdata[SAMPLE_BITS-1:0]),
      .last      (req_tlast),
      .threshold (threshold_ff),
      .scan_next (scan_next)
   );

   // The divide runs even with no hits; the result is masked to zero then.
   lsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scan_next.sum),
      .divisor  (scan_next.hits),
      .stat     (div_stat)
   );

   // Sequencer: idle (taking samples), dividing, holding a finished result.
   always_comb begin
      state_in = state_ff;
      load     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (div_start) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               if (out_free) begin
                  load     = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_wr_en) threshold_in = csr_wr_data;
   end

   // Capture the scan's bit vector and hit flag when the division starts.
   always_comb begin
      bits_in = bits_ff;
      seen_in = seen_ff;
      if (div_start) begin
         bits_in = scan_next.bits;
         seen_in = (scan_next.hits != '0);
      end
   end

   // Load the output register from the quotient; force zeros with no line.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_bits_in  = rsp_bits_ff;
      rsp_seen_in  = rsp_seen_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_seen_in  = seen_ff;
         if (seen_ff) begin
            rsp_pos_in  = div_stat.quotient[OUT_W-1:0];
            rsp_err_in  = div_stat.quotient[OUT_W-1:0] - CENTRE_POS;
            rsp_bits_in = bits_ff;
         end else begin
            rsp_pos_in  = '0;
            rsp_err_in  = '0;
            rsp_bits_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff     <= bits_in;
      seen_ff     <= seen_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_bits_ff <= rsp_bits_in;
      rsp_seen_ff <= rsp_seen_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_bits_ff, rsp_err_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_seen_ff;

`ifndef SYNTH
   // A scan end always blocks the request side for the divide.
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("request accepted right after a scan end");

   // The divider finishes only while the sequencer waits for it.
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide state");

   // No line seen means an all-zero result.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("nonzero result without a line");
`endif

endmodule
